### hw/rtl/tqc_pkg.sv
// shared types and constants for the textured quad clip unit
package tqc_pkg;

  localparam int unsigned PixW   = 16;
  localparam int unsigned TexW   = 17;
  localparam int unsigned DenW   = 17;
  localparam int unsigned NumW   = 2 * DenW;
  localparam int unsigned DivDep = NumW;
  localparam int unsigned Lanes  = 4;
  localparam int unsigned Latency = DivDep + 3;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  localparam logic [PixW-1:0] ClipLeftRst   = 16'sd0;
  localparam logic [PixW-1:0] ClipTopRst    = 16'sd0;
  localparam logic [PixW-1:0] ClipRightRst  = 16'sd32767;
  localparam logic [PixW-1:0] ClipBottomRst = 16'sd32767;

  typedef struct packed {
    logic                   kind;
    logic signed [PixW-1:0] quad_left;
    logic signed [PixW-1:0] quad_top;
    logic signed [PixW-1:0] quad_right;
    logic signed [PixW-1:0] quad_bottom;
    logic [TexW-1:0]        uv_left;
    logic [TexW-1:0]        uv_top;
    logic [TexW-1:0]        uv_right;
    logic [TexW-1:0]        uv_bottom;
  } in_t;

  typedef struct packed {
    logic                   visible;
    logic signed [PixW-1:0] out_left;
    logic signed [PixW-1:0] out_top;
    logic signed [PixW-1:0] out_right;
    logic signed [PixW-1:0] out_bottom;
    logic [TexW-1:0]        out_uv_left;
    logic [TexW-1:0]        out_uv_top;
    logic [TexW-1:0]        out_uv_right;
    logic [TexW-1:0]        out_uv_bottom;
  } out_t;

  typedef struct packed {
    logic signed [PixW-1:0] left;
    logic signed [PixW-1:0] top;
    logic signed [PixW-1:0] right;
    logic signed [PixW-1:0] bottom;
  } clip_t;

  // data that rides alongside the divider lanes
  typedef struct packed {
    logic                   visible;
    logic signed [PixW-1:0] left;
    logic signed [PixW-1:0] top;
    logic signed [PixW-1:0] right;
    logic signed [PixW-1:0] bottom;
    logic [TexW-1:0]        uv_left;
    logic [TexW-1:0]        uv_top;
    logic [TexW-1:0]        uv_right;
    logic [TexW-1:0]        uv_bottom;
    logic [Lanes-1:0]       use_lerp;
    logic [Lanes-1:0]       neg;
  } side_t;

endpackage

### hw/rtl/textured_quad_clip_unit.sv
// top level of the textured quad clip unit
// an accepted start goes through the front, the delay line and the output register
// throughput: one quad per cycle, busy is never raised
// the 34-stage divider pipeline sets the latency
// reset: synchronous active-low, clears valid bits and loads clip frame 0,0,32767,32767
// results cannot be stalled, every transfer is taken as strobed
module textured_quad_clip_unit
  import tqc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_t             in_item,
  output logic            out_valid,
  output out_t            out_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [PixW-1:0] cfg_data
);

  clip_t clip_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // clip frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.left   <= ClipLeftRst;
      clip_r.top    <= ClipTopRst;
      clip_r.right  <= ClipRightRst;
      clip_r.bottom <= ClipBottomRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_LEFT:   clip_r.left   <= cfg_data;
        REG_CLIP_TOP:    clip_r.top    <= cfg_data;
        REG_CLIP_RIGHT:  clip_r.right  <= cfg_data;
        REG_CLIP_BOTTOM: clip_r.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            fv;
  side_t           fside;
  logic [NumW-1:0] fnum [Lanes];
  logic [DenW-1:0] fden [Lanes];
  logic [TexW-1:0] quo  [Lanes];
  logic            dv;
  side_t           dside;

  tqc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .clip     (clip_r),
    .valid_o  (fv),
    .side_o   (fside),
    .num_o    (fnum),
    .den_o    (fden)
  );

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    tqc_div u_div (
      .clk   (clk),
      .num_i (fnum[k]),
      .den_i (fden[k]),
      .quo_o (quo[k])
    );
  end

  tqc_delay u_delay (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (fv),
    .side_i  (fside),
    .valid_o (dv),
    .side_o  (dside)
  );

  logic [TexW:0] sum_c [Lanes];
  logic [TexW-1:0] base_c [Lanes];
  out_t out_nxt;

  // add signed quotient onto the near coordinate
  always_comb begin
    base_c[0] = dside.uv_left;
    base_c[1] = dside.uv_left;
    base_c[2] = dside.uv_top;
    base_c[3] = dside.uv_top;
    for (int k = 0; k < Lanes; k++) begin
      sum_c[k] = {1'b0, base_c[k]} + (dside.neg[k] ? -{1'b0, quo[k]} : {1'b0, quo[k]});
    end
    out_nxt = '0;
    if (dside.visible) begin
      out_nxt.visible       = 1'b1;
      out_nxt.out_left      = dside.left;
      out_nxt.out_top       = dside.top;
      out_nxt.out_right     = dside.right;
      out_nxt.out_bottom    = dside.bottom;
      out_nxt.out_uv_left   = dside.use_lerp[0] ? sum_c[0][TexW-1:0] : dside.uv_left;
      out_nxt.out_uv_right  = dside.use_lerp[1] ? sum_c[1][TexW-1:0] : dside.uv_right;
      out_nxt.out_uv_top    = dside.use_lerp[2] ? sum_c[2][TexW-1:0] : dside.uv_top;
      out_nxt.out_uv_bottom = dside.use_lerp[3] ? sum_c[3][TexW-1:0] : dside.uv_bottom;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv;
    end
    out_item <= out_nxt;
  end

  // every accepted quad comes out a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("accepted quad did not produce a result transfer");

  // a culled result carries zeros
  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.visible) |-> (out_item == '0))
    else $error("culled result has non-zero fields");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

### hw/rtl/tqc_front.sv
// edge tests, clamp and interpolation products (two register stages)
module tqc_front
  import tqc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_t                   in_item,
  input  clip_t                 clip,
  output logic                  valid_o,
  output side_t                 side_o,
  output logic [NumW-1:0]       num_o [Lanes],
  output logic [DenW-1:0]       den_o [Lanes]
);

  logic signed [PixW:0] a_c [Lanes];
  logic signed [PixW:0] sph_c, spv_c;
  logic signed [TexW:0] dh_c, dv_c;
  logic lt_l, gt_l, lt_r, gt_r, lt_t, gt_t, lt_b, gt_b;
  side_t side_c;

  // stage one logic: compares and differences
  always_comb begin
    a_c[0] = {clip.left[PixW-1], clip.left} - {in_item.quad_left[PixW-1], in_item.quad_left};
    a_c[1] = {clip.right[PixW-1], clip.right} - {in_item.quad_left[PixW-1], in_item.quad_left};
    a_c[2] = {clip.top[PixW-1], clip.top} - {in_item.quad_top[PixW-1], in_item.quad_top};
    a_c[3] = {clip.bottom[PixW-1], clip.bottom} - {in_item.quad_top[PixW-1], in_item.quad_top};
    sph_c = {in_item.quad_right[PixW-1], in_item.quad_right}
          - {in_item.quad_left[PixW-1], in_item.quad_left};
    spv_c = {in_item.quad_bottom[PixW-1], in_item.quad_bottom}
          - {in_item.quad_top[PixW-1], in_item.quad_top};
    dh_c = {1'b0, in_item.uv_right} - {1'b0, in_item.uv_left};
    dv_c = {1'b0, in_item.uv_bottom} - {1'b0, in_item.uv_top};
    lt_l = in_item.quad_left < clip.left;
    gt_l = in_item.quad_left > clip.right;
    lt_r = in_item.quad_right < clip.left;
    gt_r = in_item.quad_right > clip.right;
    lt_t = in_item.quad_top < clip.top;
    gt_t = in_item.quad_top > clip.bottom;
    lt_b = in_item.quad_bottom < clip.top;
    gt_b = in_item.quad_bottom > clip.bottom;

    side_c = '0;
    side_c.uv_left   = in_item.uv_left;
    side_c.uv_top    = in_item.uv_top;
    side_c.uv_right  = in_item.uv_right;
    side_c.uv_bottom = in_item.uv_bottom;
    if (in_item.kind) begin
      // highlight clamp, start bound wins
      side_c.visible = 1'b1;
      side_c.left   = lt_l ? clip.left : (gt_l ? clip.right : in_item.quad_left);
      side_c.right  = lt_r ? clip.left : (gt_r ? clip.right : in_item.quad_right);
      side_c.top    = lt_t ? clip.top : (gt_t ? clip.bottom : in_item.quad_top);
      side_c.bottom = lt_b ? clip.top : (gt_b ? clip.bottom : in_item.quad_bottom);
    end else begin
      side_c.visible = !((!lt_l && gt_l) || lt_r || (!lt_t && gt_t) || lt_b);
      side_c.left   = lt_l ? clip.left : in_item.quad_left;
      side_c.right  = (!lt_r && gt_r) ? clip.right : in_item.quad_right;
      side_c.top    = lt_t ? clip.top : in_item.quad_top;
      side_c.bottom = (!lt_b && gt_b) ? clip.bottom : in_item.quad_bottom;
      side_c.use_lerp[0] = lt_l && (sph_c != '0);
      side_c.use_lerp[1] = !lt_r && gt_r && (sph_c != '0);
      side_c.use_lerp[2] = lt_t && (spv_c != '0);
      side_c.use_lerp[3] = !lt_b && gt_b && (spv_c != '0);
    end
  end

  logic                 v1_r;
  side_t                side1_r;
  logic [PixW:0]        a1_r [Lanes];
  logic [PixW:0]        sph1_r, spv1_r;
  logic signed [TexW:0] dh1_r, dv1_r;

  // stage one registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    side1_r <= side_c;
    for (int i = 0; i < Lanes; i++) begin
      a1_r[i] <= a_c[i];
    end
    sph1_r <= sph_c;
    spv1_r <= spv_c;
    dh1_r  <= dh_c;
    dv1_r  <= dv_c;
  end

  logic [TexW:0]   mh_full, mv_full;
  logic [DenW-1:0] mh_c, mv_c;
  logic [PixW:0]   am_c [Lanes];
  side_t           side2_c;

  // magnitudes of the offsets and texture deltas, sign of each product
  always_comb begin
    mh_full = dh1_r[TexW] ? -dh1_r : dh1_r;
    mv_full = dv1_r[TexW] ? -dv1_r : dv1_r;
    mh_c = mh_full[DenW-1:0];
    mv_c = mv_full[DenW-1:0];
    for (int i = 0; i < Lanes; i++) begin
      am_c[i] = a1_r[i][PixW] ? -a1_r[i] : a1_r[i];
    end
    side2_c = side1_r;
    side2_c.neg = {a1_r[3][PixW] ^ dv1_r[TexW], a1_r[2][PixW] ^ dv1_r[TexW],
                   a1_r[1][PixW] ^ dh1_r[TexW], a1_r[0][PixW] ^ dh1_r[TexW]};
  end

  // stage two registers: products into the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_r;
    end
    side_o <= side2_c;
    num_o[0] <= NumW'(am_c[0]) * NumW'(mh_c);
    num_o[1] <= NumW'(am_c[1]) * NumW'(mh_c);
    num_o[2] <= NumW'(am_c[2]) * NumW'(mv_c);
    num_o[3] <= NumW'(am_c[3]) * NumW'(mv_c);
    den_o[0] <= sph1_r[DenW-1:0];
    den_o[1] <= sph1_r[DenW-1:0];
    den_o[2] <= spv1_r[DenW-1:0];
    den_o[3] <= spv1_r[DenW-1:0];
  end

endmodule

### hw/rtl/tqc_div.sv
// pipelined restoring divider lane, one quotient bit per stage
module tqc_div
  import tqc_pkg::*;
(
  input  logic            clk,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [TexW-1:0] quo_o
);

  logic [DenW-1:0] rem_s [DivDep+1];
  logic [NumW-1:0] low_s [DivDep+1];
  logic [TexW-1:0] quo_s [DivDep+1];
  logic [DenW-1:0] den_s [DivDep+1];

  // entry: remainder starts empty, the whole dividend is shifted in
  always_comb begin
    rem_s[0] = '0;
    low_s[0] = num_i;
    quo_s[0] = '0;
    den_s[0] = den_i;
  end

  for (genvar i = 0; i < DivDep; i++) begin : g_stage
    logic [DenW:0] trial;
    logic          ge;

    // shift in one dividend bit and try the subtract
    always_comb begin
      trial = {rem_s[i], low_s[i][NumW-1]};
      ge    = trial >= {1'b0, den_s[i]};
    end

    // low quotient bits are kept, the result wraps at the texture width
    always_ff @(posedge clk) begin
      rem_s[i+1] <= ge ? DenW'(trial - {1'b0, den_s[i]}) : trial[DenW-1:0];
      low_s[i+1] <= {low_s[i][NumW-2:0], 1'b0};
      quo_s[i+1] <= {quo_s[i][TexW-2:0], ge};
      den_s[i+1] <= den_s[i];
    end
  end

  assign quo_o = quo_s[DivDep];

endmodule

### hw/rtl/tqc_delay.sv
// side data and valid delay line matching the divider depth
module tqc_delay
  import tqc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  input  side_t side_i,
  output logic  valid_o,
  output side_t side_o
);

  logic  v_r    [DivDep];
  side_t side_r [DivDep];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivDep; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= valid_i;
      for (int i = 1; i < DivDep; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    side_r[0] <= side_i;
    for (int i = 1; i < DivDep; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign valid_o = v_r[DivDep-1];
  assign side_o  = side_r[DivDep-1];

endmodule

### sim/textured_quad_clip_checker.sv
// checker for the textured quad clip unit: frame tracking, clip prediction and result compare
`timescale 1ns / 1ps

module textured_quad_clip_checker
  import tqc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  in_t             in_item,
  input  logic            out_valid,
  input  out_t            out_item,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [PixW-1:0] cfg_data,
  output int              mismatches,
  output int              pending,
  output int              checked
);

  // local copy of the clip frame
  logic signed [PixW-1:0] frame_left, frame_top, frame_right, frame_bottom;
  out_t expected_clips[$];

  assign pending = expected_clips.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch #%0d on %s: got %0d, want %0d", $time, checked, what, got, want);
    mismatches++;
  endtask

  // texture coordinate at pos, from the unclipped near edge, quotient truncated toward zero
  function automatic longint tex_at(input longint near_tc, input longint far_tc,
                                    input longint pos, input longint from_px,
                                    input longint to_px);
    longint span;
    span = to_px - from_px;
    if (span == 0) return near_tc;
    return near_tc + ((pos - from_px) * (far_tc - near_tc)) / span;
  endfunction

  function automatic logic signed [PixW-1:0] clamp_px(input logic signed [PixW-1:0] v,
                                                      input logic signed [PixW-1:0] lo,
                                                      input logic signed [PixW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic out_t clip_quad(input in_t q);
    out_t   r;
    logic   shown;
    longint u;
    shown = 1'b1;
    r.visible       = 1'b1;
    r.out_left      = q.quad_left;
    r.out_top       = q.quad_top;
    r.out_right     = q.quad_right;
    r.out_bottom    = q.quad_bottom;
    r.out_uv_left   = q.uv_left;
    r.out_uv_top    = q.uv_top;
    r.out_uv_right  = q.uv_right;
    r.out_uv_bottom = q.uv_bottom;
    if (q.kind) begin
      r.out_left   = clamp_px(q.quad_left, frame_left, frame_right);
      r.out_right  = clamp_px(q.quad_right, frame_left, frame_right);
      r.out_top    = clamp_px(q.quad_top, frame_top, frame_bottom);
      r.out_bottom = clamp_px(q.quad_bottom, frame_top, frame_bottom);
    end else begin
      // horizontal axis
      if (q.quad_left < frame_left) begin
        u = tex_at(q.uv_left, q.uv_right, frame_left, q.quad_left, q.quad_right);
        r.out_uv_left = u[TexW-1:0];
        r.out_left = frame_left;
      end else if (q.quad_left > frame_right) begin
        shown = 1'b0;
      end
      if (q.quad_right < frame_left) begin
        shown = 1'b0;
      end else if (q.quad_right > frame_right) begin
        u = tex_at(q.uv_left, q.uv_right, frame_right, q.quad_left, q.quad_right);
        r.out_uv_right = u[TexW-1:0];
        r.out_right = frame_right;
      end
      // vertical axis
      if (q.quad_top < frame_top) begin
        u = tex_at(q.uv_top, q.uv_bottom, frame_top, q.quad_top, q.quad_bottom);
        r.out_uv_top = u[TexW-1:0];
        r.out_top = frame_top;
      end else if (q.quad_top > frame_bottom) begin
        shown = 1'b0;
      end
      if (q.quad_bottom < frame_top) begin
        shown = 1'b0;
      end else if (q.quad_bottom > frame_bottom) begin
        u = tex_at(q.uv_top, q.uv_bottom, frame_bottom, q.quad_top, q.quad_bottom);
        r.out_uv_bottom = u[TexW-1:0];
        r.out_bottom = frame_bottom;
      end
    end
    if (!shown) r = '0;
    return r;
  endfunction

  // watch register writes, accepted quads and result strobes
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      frame_left   <= ClipLeftRst;
      frame_top    <= ClipTopRst;
      frame_right  <= ClipRightRst;
      frame_bottom <= ClipBottomRst;
      expected_clips.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_CLIP_LEFT:   frame_left   <= cfg_data;
          REG_CLIP_TOP:    frame_top    <= cfg_data;
          REG_CLIP_RIGHT:  frame_right  <= cfg_data;
          REG_CLIP_BOTTOM: frame_bottom <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_clips.push_back(clip_quad(in_item));
      if (out_valid) begin
        if (expected_clips.size() == 0) begin
          report("result transfer with nothing expected", 1, 0);
        end else begin
          want = expected_clips.pop_front();
          if (out_item.visible !== want.visible)
            report("visible", out_item.visible, want.visible);
          if (out_item.out_left !== want.out_left)
            report("out_left", out_item.out_left, want.out_left);
          if (out_item.out_top !== want.out_top)
            report("out_top", out_item.out_top, want.out_top);
          if (out_item.out_right !== want.out_right)
            report("out_right", out_item.out_right, want.out_right);
          if (out_item.out_bottom !== want.out_bottom)
            report("out_bottom", out_item.out_bottom, want.out_bottom);
          if (out_item.out_uv_left !== want.out_uv_left)
            report("out_uv_left", out_item.out_uv_left, want.out_uv_left);
          if (out_item.out_uv_top !== want.out_uv_top)
            report("out_uv_top", out_item.out_uv_top, want.out_uv_top);
          if (out_item.out_uv_right !== want.out_uv_right)
            report("out_uv_right", out_item.out_uv_right, want.out_uv_right);
          if (out_item.out_uv_bottom !== want.out_uv_bottom)
            report("out_uv_bottom", out_item.out_uv_bottom, want.out_uv_bottom);
          checked++;
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    checked = 0;
  end

endmodule

### sim/textured_quad_clip_unit_test.sv
// top of the textured quad clip unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module textured_quad_clip_unit_test
  import tqc_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int RandPerFrame = 180;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_t             in_item = '0;
  logic            out_valid;
  out_t            out_item;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [PixW-1:0] cfg_data = '0;
  int              mismatches, pending, checked;
  int              cycles = 0;
  int              sent = 0;
  // frame as programmed, used to aim the random quads
  int              fl = 0, ft = 0, fr = 32767, fb = 32767;

  always #5 clk = ~clk;

  textured_quad_clip_unit uut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  textured_quad_clip_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .checked
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** textured_quad_clip_unit: FAILED **");
      $finish;
    end
  end

  // one quad transfer, start is left high for a following item
  task automatic send_quad(input logic k, input int l, input int t, input int r, input int b,
                           input int ul, input int ut, input int ur, input int ub);
    in_t q;
    q.kind = k;
    q.quad_left = l[15:0];
    q.quad_top = t[15:0];
    q.quad_right = r[15:0];
    q.quad_bottom = b[15:0];
    q.uv_left = ul[16:0];
    q.uv_top = ut[16:0];
    q.uv_right = ur[16:0];
    q.uv_bottom = ub[16:0];
    in_item <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for the pipeline to empty before touching the frame
  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // valid stays high across back to back writes
  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_index <= idx;
    cfg_data <= val[15:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_frame(input int l, input int t, input int r, input int b);
    drain();
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
    cfg_valid <= 1'b0;
    fl = l; ft = t; fr = r; fb = b;
  endtask

  function automatic int sat16(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // coordinate mostly near one of the two frame edges, sometimes anywhere
  function automatic int pick_px(input int lo, input int hi);
    case ($urandom_range(0, 4))
      0: return $signed(16'($urandom));
      1, 2: return sat16(lo + $urandom_range(0, 80) - 40);
      default: return sat16(hi + $urandom_range(0, 80) - 40);
    endcase
  endfunction

  function automatic int pick_uv();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic random_quad;
    int a, b2, c, d;
    a = pick_px(fl, fr);
    b2 = pick_px(fl, fr);
    c = pick_px(ft, fb);
    d = pick_px(ft, fb);
    // mostly well ordered, some inverted rectangles
    if ($urandom_range(0, 9) != 0) begin
      if (a > b2) begin a = a ^ b2; b2 = a ^ b2; a = a ^ b2; end
      if (c > d) begin c = c ^ d; d = c ^ d; c = c ^ d; end
    end
    send_quad($urandom_range(0, 1), a, c, b2, d, pick_uv(), pick_uv(), pick_uv(), pick_uv());
  endtask

  task automatic random_run(input int n, input bit calm_tail);
    for (int i = 0; i < n; i++) begin
      random_quad();
      if (!(calm_tail && i > n - 150) && $urandom_range(0, 5) == 0)
        pause($urandom_range(1, 18));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset frame 0,0,32767,32767
    send_quad(0, -32768, -32768, 32767, 32767, 0, 65536, 65536, 0);
    send_quad(1, -32768, -32768, 32767, 32767, 65536, 0, 0, 65536);
    send_quad(0, -100, -10, -1, 20, 10, 20, 30, 40);       // culled left of frame
    send_quad(0, 5, -20, 10, -1, 10, 20, 30, 40);          // culled above frame
    send_quad(0, -3, -7, 9, 13, 0, 65536, 65536, 0);       // clipped left and top
    send_quad(0, 0, 0, 0, 0, 65536, 65536, 65536, 65536);
    send_quad(1, -5, -5, -1, -2, 1, 2, 3, 4);              // highlight clamped to start
    pause(3);
    send_quad(0, 30, 40, 10, 5, 100, 200, 300, 400);       // inverted rectangle

    // directed: narrow frame
    set_frame(100, 50, 400, 300);
    send_quad(0, 50, 20, 500, 350, 0, 0, 65536, 65536);    // clipped left, top, right and bottom
    send_quad(0, 401, 60, 500, 70, 1, 2, 3, 4);            // culled right of frame
    send_quad(0, 120, 301, 130, 310, 1, 2, 3, 4);          // culled below frame
    send_quad(1, 50, 20, 500, 350, 5, 6, 7, 8);
    send_quad(1, 200, 100, 250, 150, 5, 6, 7, 8);          // highlight inside, untouched
    send_quad(0, 100, 50, 400, 300, 9, 8, 7, 6);           // exactly on the frame
    send_quad(0, 99, 49, 401, 301, 65536, 0, 0, 65536);
    random_run(RandPerFrame, 0);

    // inverted frame, where a clipped edge can have zero span
    set_frame(300, 200, 100, 50);
    send_quad(0, 200, 100, 200, 100, 11, 22, 33, 44);
    send_quad(1, 200, 100, 200, 100, 11, 22, 33, 44);
    send_quad(0, 0, 0, 500, 500, 0, 0, 65536, 65536);
    random_run(RandPerFrame / 2, 0);
    // hold off until every result has come back
    drain();
    random_run(RandPerFrame / 2, 0);

    // full signed range
    set_frame(-32768, -32768, 32767, 32767);
    send_quad(0, -32768, 32767, 32767, -32768, 65536, 0, 0, 65536);
    random_run(RandPerFrame, 0);

    // single pixel frame at the far corner
    set_frame(32767, -32768, 32767, -32768);
    random_run(RandPerFrame / 2, 0);

    // random frame, then back to reset values
    set_frame(-1000 + $urandom_range(0, 2000), -1000 + $urandom_range(0, 2000),
              $urandom_range(0, 3000), $urandom_range(0, 3000));
    random_run(RandPerFrame / 2, 0);
    set_frame(0, 0, 32767, 32767);
    random_run(RandPerFrame, 1);

    drain();
    $display("%0d quads sent, %0d results checked across seven clip frames", sent, checked);
    $display("glyph cull/clip and highlight clamp, incl. inverted frame and rectangles");
    if (mismatches == 0 && pending == 0) begin
      $display("** textured_quad_clip_unit: PASSED **");
    end else begin
      $display("** textured_quad_clip_unit: FAILED **");
    end
    $finish;
  end

endmodule

### textured_quad_clip_unit.f
hw/rtl/tqc_pkg.sv
hw/rtl/tqc_front.sv
hw/rtl/tqc_div.sv
hw/rtl/tqc_delay.sv
hw/rtl/textured_quad_clip_unit.sv
sim/textured_quad_clip_checker.sv
sim/textured_quad_clip_unit_test.sv
